// ----- sv/cell_fourier_cos_moment_accumulator_defines.svh -----
// assertion helpers for the rtl sequencer
`ifndef CELL_FOURIER_COS_MOMENT_ACCUMULATOR_DEFINES_SVH
`define CELL_FOURIER_COS_MOMENT_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CFCMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define CFCMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/cfcma_pkg.sv -----
package cfcma_pkg;

  localparam int CELL_COUNT_DEF = 1024;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int SUM_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 2'd3;

  localparam logic [1:0] OP_ACC    = 2'd0;
  localparam logic [1:0] OP_CLR    = 2'd1;
  localparam logic [1:0] OP_RD     = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
  localparam logic [2:0]  HORNER_LAST = 3'd4;

  localparam int DIV_W         = 48;
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_STEPS     = DIV_W / DIV_STEP_BITS;

  // datapath step codes
  localparam logic [3:0] STEP_NONE = 4'd0;
  localparam logic [3:0] STEP_PH0  = 4'd1;
  localparam logic [3:0] STEP_PH1  = 4'd2;
  localparam logic [3:0] STEP_PH2  = 4'd3;
  localparam logic [3:0] STEP_CX   = 4'd4;
  localparam logic [3:0] STEP_CX2  = 4'd5;
  localparam logic [3:0] STEP_HMUL = 4'd6;
  localparam logic [3:0] STEP_HUPD = 4'd7;
  localparam logic [3:0] STEP_COS  = 4'd8;
  localparam logic [3:0] STEP_EMUL = 4'd9;
  localparam logic [3:0] STEP_PMLO = 4'd10;
  localparam logic [3:0] STEP_PMHI = 4'd11;
  localparam logic [3:0] STEP_HDIV = 4'd12;

  // result kinds
  localparam logic [1:0] KIND_ZERO   = 2'd0;
  localparam logic [1:0] KIND_STORED = 2'd1;
  localparam logic [1:0] KIND_SUM    = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         cell_index;
    logic [15:0]        cell_count;
    logic signed [31:0] scalar_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } item_t;

  typedef struct packed {
    logic       load;
    logic       clr_wr;
    logic       wr_zero;
    logic       wr_sum;
    logic       ram_rd;
    logic       cap_stored;
    logic [3:0] step;
    logic       div_go;
    logic       res_load;
    logic [1:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic       bad;
    logic [1:0] op;
    logic       cnt_zero;
    logic       clr_last;
    logic       div_done;
    logic       h_last;
    logic       m_zero;
    logic       out_free;
  } stat_t;

  // floor(n / d) for n < 2^32 is (n * m) >> s, d = 90, 56, 30, 12, 2 in series order
  function automatic logic [32:0] horner_recip(input logic [2:0] i);
    logic [32:0] m;
    case (i)
      3'd0: m = 33'd6108397933;
      3'd1: m = 33'd4908534053;
      3'd2: m = 33'd4581298450;
      3'd3: m = 33'd5726623062;
      3'd4: m = 33'd4294967296;
      default: m = 33'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] horner_shift(input logic [2:0] i);
    logic [5:0] s;
    case (i)
      3'd0: s = 6'd39;
      3'd1: s = 6'd38;
      3'd2: s = 6'd37;
      3'd3: s = 6'd36;
      3'd4: s = 6'd33;
      default: s = 6'd32;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/cfcma_in_if.sv -----
interface cfcma_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [9:0]         cell_index;
  logic [15:0]        cell_count;
  logic signed [31:0] scalar_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, opcode, cell_index, cell_count, scalar_value,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, opcode, cell_index, cell_count, scalar_value,
                pos_x, pos_y, pos_z, output ready);
endinterface

// ----- sv/cfcma_out_if.sv -----
interface cfcma_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cfcma_pkg::SUM_W-1:0]   cell_sum;
  logic                                 skipped;
  logic                                 saturated;

  modport source (output valid, cell_sum, skipped, saturated, input ready);
  modport sink (input valid, cell_sum, skipped, saturated, output ready);
endinterface

// ----- sv/cfcma_cfg_if.sv -----
interface cfcma_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cfcma_pkg::CFG_IDX_W-1:0]   index;
  logic [cfcma_pkg::CFG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/cell_fourier_cos_moment_accumulator.sv -----
// channel | dir | handshake     | payload
// in_ch   | in  | valid / ready | opcode, cell_index, cell_count, scalar_value, pos_x/y/z
// out_ch  | out | valid / ready | cell_sum, skipped, saturated
// cfg_ch  | in  | valid / ready | index, data (ready always high)
//
// after reset a clearing sweep zeroes the cell store; no input is taken meanwhile
// clear, read, skipped or rejected transactions go from decode to the result register without the arithmetic
// accumulate time is set mostly by the count divide on the 4-bit-per-cycle divider
// (a start state and a wait state) and the power loop; the series divides by constants
// are reciprocal multiplies
// one transaction in flight; the result register lets the next one be taken
// while out_ch stalls, a second finished result waits until the first is taken
module cell_fourier_cos_moment_accumulator #(
  parameter int CELL_COUNT = cfcma_pkg::CELL_COUNT_DEF,
  parameter int ANGLE_BITS = cfcma_pkg::ANGLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  cfcma_in_if.sink   in_ch,
  cfcma_out_if.source out_ch,
  cfcma_cfg_if.sink  cfg_ch
);
  cfcma_pkg::cmd_t  cmd;
  cfcma_pkg::stat_t stat;
  cfcma_pkg::item_t in_item;

  // config writes are taken at any time
  assign cfg_ch.ready = 1'b1;

  // pack the input payload
  always_comb begin
    in_item.opcode       = in_ch.opcode;
    in_item.cell_index   = in_ch.cell_index;
    in_item.cell_count   = in_ch.cell_count;
    in_item.scalar_value = in_ch.scalar_value;
    in_item.pos_x        = in_ch.pos_x;
    in_item.pos_y        = in_ch.pos_y;
    in_item.pos_z        = in_ch.pos_z;
  end

  // sequencer
  cfcma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, cell store, result register
  cfcma_datapath #(
    .CELL_COUNT (CELL_COUNT),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_item       (in_item),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_cell_sum  (out_ch.cell_sum),
    .out_skipped   (out_ch.skipped),
    .out_saturated (out_ch.saturated)
  );
endmodule

// ----- sv/cfcma_ram.sv -----
module cfcma_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- sv/cfcma_div.sv -----
module cfcma_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [cfcma_pkg::DIV_W-1:0]  dividend,
  input  logic [15:0]                  divisor,
  output logic [cfcma_pkg::DIV_W-1:0]  quo,
  output logic                         done
);
  localparam int CW = $clog2(cfcma_pkg::DIV_STEPS + 1);

  logic [cfcma_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [15:0]                 rem_r, rem_nxt;
  logic [15:0]                 d_r;
  logic [CW-1:0]               cnt_r;
  logic                        busy_r;
  logic                        done_r;

  // DIV_STEP_BITS restoring steps per cycle while busy, dividend bits shift out the top of quo_r
  always_comb begin
    logic [16:0]                 t;
    logic [cfcma_pkg::DIV_W-1:0] q;
    logic [15:0]                 r;
    r = rem_r;
    q = quo_r;
    for (int j = 0; j < cfcma_pkg::DIV_STEP_BITS; j++) begin
      t = {r, q[cfcma_pkg::DIV_W-1]};
      q = {q[cfcma_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, d_r}) begin
        t = t - {1'b0, d_r};
        q[0] = 1'b1;
      end
      r = t[15:0];
    end
    quo_nxt = q;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(cfcma_pkg::DIV_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;
endmodule

// ----- sv/cfcma_datapath.sv -----
module cfcma_datapath #(
  parameter int CELL_COUNT = cfcma_pkg::CELL_COUNT_DEF,
  parameter int ANGLE_BITS = cfcma_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfcma_pkg::cmd_t                   cmd,
  output cfcma_pkg::stat_t                  stat,
  input  cfcma_pkg::item_t                  in_item,
  input  logic                              cfg_we,
  input  logic [cfcma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfcma_pkg::CFG_W-1:0]       cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cfcma_pkg::SUM_W-1:0] out_cell_sum,
  output logic                              out_skipped,
  output logic                              out_saturated
);
  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int SW = cfcma_pkg::SUM_W;
  localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam logic [SW:0] LIM_POS = {2'b00, {(SW-1){1'b1}}};
  localparam logic [SW:0] LIM_NEG = {2'b01, {(SW-1){1'b0}}};

  // configuration
  logic signed [23:0] wave_x_r, wave_y_r, wave_z_r;
  logic [3:0]         order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_x_r <= '0;
      wave_y_r <= '0;
      wave_z_r <= '0;
      order_r  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        cfcma_pkg::REG_WAVE_X: wave_x_r <= cfg_data;
        cfcma_pkg::REG_WAVE_Y: wave_y_r <= cfg_data;
        cfcma_pkg::REG_WAVE_Z: wave_z_r <= cfg_data;
        cfcma_pkg::REG_ORDER:  order_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // latched item
  cfcma_pkg::item_t it_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r <= in_item;
    end
  end

  logic [31:0]   idx32;
  logic [AW-1:0] idx_addr;
  assign idx32    = 32'(it_r.cell_index);
  assign idx_addr = idx32[AW-1:0];

  // cell store and clearing sweep
  logic [AW-1:0]         clr_addr_r;
  logic [SW-1:0]         ram_rdata;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [SW-1:0]         ram_wdata;
  logic signed [SW-1:0]  sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_comb begin
    ram_we    = cmd.clr_wr | cmd.wr_zero | cmd.wr_sum;
    ram_waddr = cmd.clr_wr ? clr_addr_r : idx_addr;
    ram_wdata = cmd.wr_sum ? sum_nxt : '0;
  end

  cfcma_ram #(.WIDTH(SW), .DEPTH(1 << AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.ram_rd),
    .raddr (idx_addr),
    .rdata (ram_rdata)
  );

  logic signed [SW-1:0] stored_r;
  always_ff @(posedge clk) begin
    if (cmd.cap_stored) begin
      stored_r <= ram_rdata;
    end
  end

  // phase
  logic [31:0]        phase_r;
  logic signed [23:0] ph_a;
  logic signed [31:0] ph_b;
  logic signed [55:0] ph_prod;

  always_comb begin
    case (cmd.step)
      cfcma_pkg::STEP_PH0: begin ph_a = wave_x_r; ph_b = it_r.pos_x; end
      cfcma_pkg::STEP_PH1: begin ph_a = wave_y_r; ph_b = it_r.pos_y; end
      default:             begin ph_a = wave_z_r; ph_b = it_r.pos_z; end
    endcase
    ph_prod = ph_a * ph_b;
  end

  // fold into the first quadrant and convert to radians
  logic [31:0] t0, t1, t2;
  logic        fneg;
  logic [61:0] x_prod;
  logic [30:0] x_r;
  logic        neg_r;
  logic [61:0] xx_prod;
  logic [31:0] x2_r;

  always_comb begin
    t0      = phase_r & ANG_MASK;
    t1      = (t0 > 32'h8000_0000) ? (32'd0 - t0) : t0;
    fneg    = t1 > 32'h4000_0000;
    t2      = fneg ? (32'h8000_0000 - t1) : t1;
    x_prod  = 62'(t2[30:0]) * 62'(cfcma_pkg::TWO_PI_Q28);
    xx_prod = 62'(x_r) * 62'(x_r);
  end

  // horner series; the constant divides are reciprocal multiplies on the magnitude
  logic signed [31:0] h_r;
  logic [2:0]         hi_r;
  logic signed [64:0] hm_prod;
  logic signed [64:0] hm_sh;
  logic signed [SW-1:0] mulq_r;
  logic [31:0]        hq_abs;
  logic [64:0]        hq_prod;
  logic [64:0]        hq_sh;
  logic signed [31:0] hq_r;

  always_comb begin
    hm_prod = $signed({1'b0, x2_r}) * h_r;
    hm_sh   = hm_prod >>> 30;
    hq_abs  = mulq_r[SW-1] ? 32'(SW'(0) - mulq_r) : mulq_r[31:0];
    hq_prod = 65'(hq_abs) * 65'(cfcma_pkg::horner_recip(hi_r));
    hq_sh   = hq_prod >> cfcma_pkg::horner_shift(hi_r);
  end

  // divider for the cell count
  logic [SW-1:0]        div_quo;
  logic                 div_done;
  logic                 div_neg_r;
  logic signed [SW-1:0] div_src;
  logic [SW-1:0]        div_mag;
  logic [15:0]          div_d;
  logic signed [SW-1:0] div_qs;
  logic signed [SW-1:0] p_r;

  always_comb begin
    div_src = p_r;
    div_mag = div_src[SW-1] ? (SW'(0) - div_src) : div_src;
    div_d   = it_r.cell_count;
    div_qs  = div_neg_r ? (SW'(0) - div_quo) : div_quo;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      div_neg_r <= div_src[SW-1];
    end
  end

  cfcma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_mag),
    .divisor  (div_d),
    .quo      (div_quo),
    .done     (div_done)
  );

  // cosine rounding and e = scalar * cos
  logic signed [32:0] hh;
  logic signed [32:0] cs;
  logic [14:0]        cmag;
  logic signed [15:0] c_r;
  logic signed [47:0] em_prod;
  logic signed [47:0] em_sh;
  logic signed [31:0] e_r;
  logic [3:0]         ord_eff;
  logic [2:0]         m_r;

  always_comb begin
    hh = {h_r[31], h_r} + 33'sd16384;
    cs = hh >>> 15;
    if (cs[32]) begin
      cmag = '0;
    end else if (cs > 33'sd32767) begin
      cmag = 15'h7fff;
    end else begin
      cmag = cs[14:0];
    end
    em_prod = it_r.scalar_value * c_r + 48'sd16384;
    em_sh   = em_prod >>> 15;
    if (order_r == 4'd0) begin
      ord_eff = 4'd1;
    end else if (order_r > 4'd8) begin
      ord_eff = 4'd8;
    end else begin
      ord_eff = order_r;
    end
  end

  // power: 48 x 32 magnitude product in two halves
  logic [SW-1:0]  ap;
  logic [31:0]    ae;
  logic [79:0]    prod_r;
  logic [47:0]    hi_prod;
  logic [79:0]    full;
  logic [64:0]    rnd;
  logic [SW:0]    rm, lim;
  logic           pneg, psat;
  logic [SW-1:0]  rmc;

  always_comb begin
    ap      = p_r[SW-1] ? (SW'(0) - p_r) : p_r;
    ae      = e_r[31] ? (32'd0 - e_r) : e_r;
    hi_prod = 48'(ap[SW-1:32]) * 48'(ae);
    full    = prod_r + {hi_prod, 32'd0};
    rnd     = {1'b0, full[63:0]} + 65'd32768;
    rm      = rnd[64:16];
    pneg    = p_r[SW-1] ^ e_r[31];
    lim     = pneg ? LIM_NEG : LIM_POS;
    psat    = (full[79:63] != '0) || (rm > lim);
    rmc     = psat ? lim[SW-1:0] : rm[SW-1:0];
  end

  // sum with saturation
  logic signed [SW:0] s49;
  logic               ssat;
  logic signed [SW-1:0] sum_r;
  always_comb begin
    s49  = {stored_r[SW-1], stored_r} + {div_qs[SW-1], div_qs};
    ssat = s49[SW] != s49[SW-1];
    if (ssat) begin
      sum_nxt = s49[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_nxt = s49[SW-1:0];
    end
  end

  logic sat_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sat_r <= 1'b0;
    end
    case (cmd.step)
      cfcma_pkg::STEP_PH0: phase_r <= ph_prod[31:0];
      cfcma_pkg::STEP_PH1, cfcma_pkg::STEP_PH2: phase_r <= phase_r + ph_prod[31:0];
      cfcma_pkg::STEP_CX: begin
        x_r   <= x_prod[60:30];
        neg_r <= fneg;
      end
      cfcma_pkg::STEP_CX2: begin
        x2_r <= xx_prod[61:30];
        h_r  <= cfcma_pkg::Q30_ONE;
        hi_r <= '0;
      end
      cfcma_pkg::STEP_HMUL: mulq_r <= hm_sh[SW-1:0];
      cfcma_pkg::STEP_HDIV: begin
        hq_r <= mulq_r[SW-1] ? -$signed(hq_sh[31:0]) : $signed(hq_sh[31:0]);
      end
      cfcma_pkg::STEP_HUPD: begin
        h_r  <= cfcma_pkg::Q30_ONE - hq_r;
        hi_r <= hi_r + 3'd1;
      end
      cfcma_pkg::STEP_COS: c_r <= neg_r ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
      cfcma_pkg::STEP_EMUL: begin
        e_r <= em_sh[31:0];
        p_r <= {{(SW-32){em_sh[31]}}, em_sh[31:0]};
        m_r <= 3'(ord_eff - 4'd1);
      end
      cfcma_pkg::STEP_PMLO: prod_r <= {16'd0, 64'(ap[31:0]) * 64'(ae)};
      cfcma_pkg::STEP_PMHI: begin
        p_r <= pneg ? (SW'(0) - rmc) : rmc;
        m_r <= m_r - 3'd1;
        if (psat) begin
          sat_r <= 1'b1;
        end
      end
      default: ;
    endcase
    if (cmd.wr_sum) begin
      sum_r <= sum_nxt;
      if (ssat) begin
        sat_r <= 1'b1;
      end
    end
  end

  // result register
  logic                 out_valid_r;
  logic signed [SW-1:0] res_sum_r;
  logic                 res_skip_r, res_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        cfcma_pkg::KIND_STORED: begin
          res_sum_r  <= stored_r;
          res_skip_r <= it_r.opcode == cfcma_pkg::OP_ACC;
          res_sat_r  <= 1'b0;
        end
        cfcma_pkg::KIND_SUM: begin
          res_sum_r  <= sum_r;
          res_skip_r <= 1'b0;
          res_sat_r  <= sat_r;
        end
        default: begin
          res_sum_r  <= '0;
          res_skip_r <= 1'b0;
          res_sat_r  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_sum  = res_sum_r;
  assign out_skipped   = res_skip_r;
  assign out_saturated = res_sat_r;

  always_comb begin
    stat.bad      = (idx32 >= 32'(CELL_COUNT)) || (it_r.opcode == cfcma_pkg::OP_UNUSED);
    stat.op       = it_r.opcode;
    stat.cnt_zero = it_r.cell_count == 16'd0;
    stat.clr_last = 32'(clr_addr_r) == 32'(CELL_COUNT - 1);
    stat.div_done = div_done;
    stat.h_last   = hi_r == cfcma_pkg::HORNER_LAST;
    stat.m_zero   = m_r == 3'd0;
    stat.out_free = !out_valid_r || out_ready;
  end
endmodule

// ----- sv/cfcma_ctrl.sv -----
`include "cell_fourier_cos_moment_accumulator_defines.svh"

module cfcma_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cfcma_pkg::stat_t stat,
  output cfcma_pkg::cmd_t  cmd
);
  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DEC  = 5'd2;
  localparam logic [4:0] S_WZ   = 5'd3;
  localparam logic [4:0] S_RD   = 5'd4;
  localparam logic [4:0] S_RDW  = 5'd5;
  localparam logic [4:0] S_PH0  = 5'd6;
  localparam logic [4:0] S_PH1  = 5'd7;
  localparam logic [4:0] S_PH2  = 5'd8;
  localparam logic [4:0] S_CX   = 5'd9;
  localparam logic [4:0] S_CX2  = 5'd10;
  localparam logic [4:0] S_HMUL = 5'd11;
  localparam logic [4:0] S_HDS  = 5'd12;
  localparam logic [4:0] S_HDW  = 5'd13;
  localparam logic [4:0] S_COS  = 5'd14;
  localparam logic [4:0] S_EMUL = 5'd15;
  localparam logic [4:0] S_PCHK = 5'd16;
  localparam logic [4:0] S_PMLO = 5'd17;
  localparam logic [4:0] S_PMHI = 5'd18;
  localparam logic [4:0] S_PDS  = 5'd19;
  localparam logic [4:0] S_PDW  = 5'd20;
  localparam logic [4:0] S_ADD  = 5'd21;
  localparam logic [4:0] S_OUT  = 5'd22;

  logic [4:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.bad) begin
          kind_nxt  = cfcma_pkg::KIND_ZERO;
          state_nxt = S_OUT;
        end else if (stat.op == cfcma_pkg::OP_CLR) begin
          state_nxt = S_WZ;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_WZ: begin
        cmd.wr_zero = 1'b1;
        kind_nxt    = cfcma_pkg::KIND_ZERO;
        state_nxt   = S_OUT;
      end
      S_RD: begin
        cmd.ram_rd = 1'b1;
        state_nxt  = S_RDW;
      end
      S_RDW: begin
        cmd.cap_stored = 1'b1;
        if (stat.op == cfcma_pkg::OP_ACC && !stat.cnt_zero) begin
          state_nxt = S_PH0;
        end else begin
          kind_nxt  = cfcma_pkg::KIND_STORED;
          state_nxt = S_OUT;
        end
      end
      S_PH0: begin cmd.step = cfcma_pkg::STEP_PH0; state_nxt = S_PH1; end
      S_PH1: begin cmd.step = cfcma_pkg::STEP_PH1; state_nxt = S_PH2; end
      S_PH2: begin cmd.step = cfcma_pkg::STEP_PH2; state_nxt = S_CX; end
      S_CX:  begin cmd.step = cfcma_pkg::STEP_CX;  state_nxt = S_CX2; end
      S_CX2: begin cmd.step = cfcma_pkg::STEP_CX2; state_nxt = S_HMUL; end
      S_HMUL: begin cmd.step = cfcma_pkg::STEP_HMUL; state_nxt = S_HDS; end
      S_HDS: begin
        cmd.step  = cfcma_pkg::STEP_HDIV;
        state_nxt = S_HDW;
      end
      S_HDW: begin
        cmd.step  = cfcma_pkg::STEP_HUPD;
        state_nxt = stat.h_last ? S_COS : S_HMUL;
      end
      S_COS:  begin cmd.step = cfcma_pkg::STEP_COS;  state_nxt = S_EMUL; end
      S_EMUL: begin cmd.step = cfcma_pkg::STEP_EMUL; state_nxt = S_PCHK; end
      S_PCHK: state_nxt = stat.m_zero ? S_PDS : S_PMLO;
      S_PMLO: begin cmd.step = cfcma_pkg::STEP_PMLO; state_nxt = S_PMHI; end
      S_PMHI: begin cmd.step = cfcma_pkg::STEP_PMHI; state_nxt = S_PCHK; end
      S_PDS: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_PDW;
      end
      S_PDW: begin
        if (stat.div_done) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.wr_sum = 1'b1;
        kind_nxt   = cfcma_pkg::KIND_SUM;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        cmd.res_kind = kind_r;
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      kind_r  <= cfcma_pkg::KIND_ZERO;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  `CFCMA_ASSERT_IMP(a_res_free, clk, rst_n, cmd.res_load, stat.out_free, "result overrun")
  `CFCMA_ASSERT_NXT(a_clr_done, clk, rst_n, state_r == S_CLR && stat.clr_last, state_r == S_IDLE, "sweep")
  `CFCMA_ASSERT_NXT(a_accept_dec, clk, rst_n, in_valid && in_ready, state_r == S_DEC, "no decode")
  `CFCMA_ASSERT_NXT(a_div_wait, clk, rst_n, state_r == S_PDW && !stat.div_done, state_r == S_PDW, "div")
endmodule
